[src/jsud_pkg.sv]
package jsud_pkg;

  // Decoder mode
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_HALTED = 2'd3
  } mode_e;

  // Input request payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Result payload
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        done_res;
    logic [15:0] bytes_written;
  } out_t;

  localparam int unsigned MaxRes = 3;

  // Results produced by one request, oldest in entry 0
  typedef struct packed {
    logic [1:0]        count;
    out_t [MaxRes-1:0] res;
  } res_grp_t;

  localparam int unsigned CapWidth = 16;
  localparam logic [CapWidth-1:0] CapReset = 16'hFFFF;

  // Character codes
  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [7:0] ChrSlash  = 8'h2F;
  localparam logic [7:0] ChrQuote  = 8'h22;
  localparam logic [7:0] ChrN      = 8'h6E;
  localparam logic [7:0] ChrR      = 8'h72;
  localparam logic [7:0] ChrB      = 8'h62;
  localparam logic [7:0] ChrT      = 8'h74;
  localparam logic [7:0] ChrF      = 8'h66;
  localparam logic [7:0] ChrU      = 8'h75;
  localparam logic [7:0] CodeLf    = 8'h0A;
  localparam logic [7:0] CodeCr    = 8'h0D;
  localparam logic [7:0] CodeBs    = 8'h08;
  localparam logic [7:0] CodeTab   = 8'h09;
  localparam logic [7:0] CodeFf    = 8'h0C;

  // Room in bytes that a \u escape needs before it is decoded
  localparam int unsigned HexRoom = 4;

  // Hex digit value; bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

[src/json_string_unescape_decoder.sv]
// JSON string body unescaper.
// Input channel: one raw byte of the string body per request (in_req_i), with
// in_last on the final byte. Accepted when in_valid_i is high and in_stall_o low.
// Output channel: decoded bytes (out_res_o), taken when out_valid_o is high and
// out_stall_i low. Each request yields zero to three results; the final request
// of a string always yields one result with done_res set (a bare marker with
// byte_valid low if it has no data byte).
// Config channel: cfg_data_i sets the per-string byte capacity; always ready.
// A request's results are registered and start the cycle after it is accepted.
// Throughput: one request per cycle while each yields at most one result and
// the receiver does not stall; a \u escape that yields two or three bytes holds
// the input until they drain, as the result buffer drains one result per cycle.
// A stalled receiver keeps the current result steady and the input stalls once
// the buffered group cannot drain. Reset empties the result buffer, clears the
// per-string state and sets the capacity to 65535.
module json_string_unescape_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  jsud_pkg::in_t                 in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output jsud_pkg::out_t                out_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [jsud_pkg::CapWidth-1:0] cfg_data_i
);

  logic [jsud_pkg::CapWidth-1:0] cap_q;
  logic                          can_load;
  logic                          accept;
  jsud_pkg::res_grp_t            grp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !can_load;
  assign accept      = in_valid_i && can_load;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= jsud_pkg::CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  jsud_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .cap_i    (cap_q),
    .grp_o    (grp)
  );

  jsud_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .grp_i       (grp),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

[src/jsud_decode.sv]
module jsud_decode #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  jsud_pkg::in_t                     req_i,
  input  logic [jsud_pkg::CapWidth-1:0]     cap_i,
  output jsud_pkg::res_grp_t                grp_o
);

  localparam int unsigned LimWidth =
      (COUNT_WIDTH > jsud_pkg::CapWidth) ? COUNT_WIDTH : jsud_pkg::CapWidth;

  jsud_pkg::mode_e         mode_q, mode_d;
  logic [1:0]              hcnt_q, hcnt_d;
  logic [15:0]             acc_q, acc_d;
  logic                    hstop_q, hstop_d;
  logic [COUNT_WIDTH-1:0]  wc_q, wc_d;

  logic [LimWidth-1:0]     cap_ext, max_ext, lim_ext;
  logic [COUNT_WIDTH-1:0]  lim, diff;
  logic                    room_zero, room_lt4;
  logic [4:0]              hv;
  logic [15:0]             cp;
  logic [7:0]              b0, b1, b2;
  logic [1:0]              n;
  logic                    mapped_ok;
  logic [7:0]              mapped;
  logic [COUNT_WIDTH-1:0]  wc1, wc2, wc3;
  jsud_pkg::res_grp_t      grp;

  // Effective limit and remaining room
  always_comb begin
    cap_ext   = LimWidth'(cap_i);
    max_ext   = LimWidth'({COUNT_WIDTH{1'b1}});
    lim_ext   = (cap_ext < max_ext) ? cap_ext : max_ext;
    lim       = lim_ext[COUNT_WIDTH-1:0];
    diff      = lim - wc_q;
    room_zero = (wc_q >= lim);
    room_lt4  = room_zero || (diff < COUNT_WIDTH'(jsud_pkg::HexRoom));
  end

  // Saturating byte counts after one, two and three data bytes
  always_comb begin
    wc1 = (wc_q == {COUNT_WIDTH{1'b1}}) ? wc_q : wc_q + 1'b1;
    wc2 = (wc1 == {COUNT_WIDTH{1'b1}}) ? wc1 : wc1 + 1'b1;
    wc3 = (wc2 == {COUNT_WIDTH{1'b1}}) ? wc2 : wc2 + 1'b1;
  end

  // Escape letter map
  always_comb begin
    mapped_ok = 1'b1;
    mapped    = 8'h00;
    case (req_i.in_byte)
      jsud_pkg::ChrN:      mapped = jsud_pkg::CodeLf;
      jsud_pkg::ChrR:      mapped = jsud_pkg::CodeCr;
      jsud_pkg::ChrB:      mapped = jsud_pkg::CodeBs;
      jsud_pkg::ChrT:      mapped = jsud_pkg::CodeTab;
      jsud_pkg::ChrF:      mapped = jsud_pkg::CodeFf;
      jsud_pkg::ChrBslash: mapped = jsud_pkg::ChrBslash;
      jsud_pkg::ChrSlash:  mapped = jsud_pkg::ChrSlash;
      jsud_pkg::ChrQuote:  mapped = jsud_pkg::ChrQuote;
      default:             mapped_ok = 1'b0;
    endcase
  end

  // Main decode: next state and the bytes this request emits
  always_comb begin
    mode_d  = mode_q;
    hcnt_d  = hcnt_q;
    acc_d   = acc_q;
    hstop_d = hstop_q;
    n       = 2'd0;
    b0      = 8'h00;
    b1      = 8'h00;
    b2      = 8'h00;
    hv      = jsud_pkg::hex_value(req_i.in_byte);
    cp      = acc_q;

    case (mode_q)
      jsud_pkg::MODE_NORMAL: begin
        if (room_zero) begin
          mode_d = jsud_pkg::MODE_HALTED;
        end else if (req_i.in_byte == jsud_pkg::ChrBslash) begin
          mode_d = req_i.in_last ? jsud_pkg::MODE_HALTED : jsud_pkg::MODE_ESCAPE;
        end else begin
          n  = 2'd1;
          b0 = req_i.in_byte;
        end
      end
      jsud_pkg::MODE_ESCAPE: begin
        if (req_i.in_byte == jsud_pkg::ChrU) begin
          if (req_i.in_last || room_lt4) begin
            mode_d = jsud_pkg::MODE_HALTED;
          end else begin
            mode_d  = jsud_pkg::MODE_HEX;
            hcnt_d  = 2'd0;
            acc_d   = 16'h0000;
            hstop_d = 1'b0;
          end
        end else if (mapped_ok) begin
          if (room_zero) begin
            mode_d = jsud_pkg::MODE_HALTED;
          end else begin
            n      = 2'd1;
            b0     = mapped;
            mode_d = jsud_pkg::MODE_NORMAL;
          end
        end else begin
          mode_d = jsud_pkg::MODE_NORMAL;
        end
      end
      jsud_pkg::MODE_HEX: begin
        if (!hstop_q) begin
          if (!hv[4]) begin
            hstop_d = 1'b1;
          end else begin
            cp = {acc_q[11:0], hv[3:0]};
          end
        end
        acc_d = cp;
        if (hcnt_q == 2'd3) begin
          // UTF-8 encode of the gathered code point
          if (cp[15:7] == 9'd0) begin
            n  = 2'd1;
            b0 = cp[7:0];
          end else if (cp[15:11] == 5'd0) begin
            n  = 2'd2;
            b0 = {3'b110, cp[10:6]};
            b1 = {2'b10, cp[5:0]};
          end else begin
            n  = 2'd3;
            b0 = {4'b1110, cp[15:12]};
            b1 = {2'b10, cp[11:6]};
            b2 = {2'b10, cp[5:0]};
          end
          mode_d  = jsud_pkg::MODE_NORMAL;
          hcnt_d  = 2'd0;
          acc_d   = 16'h0000;
          hstop_d = 1'b0;
        end else begin
          hcnt_d = hcnt_q + 2'd1;
          if (req_i.in_last) begin
            mode_d = jsud_pkg::MODE_HALTED;
          end
        end
      end
      default: begin
      end
    endcase

    // Result group
    grp.count = n;
    grp.res[0] = '{out_byte: b0, byte_valid: 1'b1, done_res: 1'b0,
                   bytes_written: 16'(wc1)};
    grp.res[1] = '{out_byte: b1, byte_valid: 1'b1, done_res: 1'b0,
                   bytes_written: 16'(wc2)};
    grp.res[2] = '{out_byte: b2, byte_valid: 1'b1, done_res: 1'b0,
                   bytes_written: 16'(wc3)};
    case (n)
      2'd1:    wc_d = wc1;
      2'd2:    wc_d = wc2;
      2'd3:    wc_d = wc3;
      default: wc_d = wc_q;
    endcase

    // End of string: flag last result or emit a bare marker, then clear
    if (req_i.in_last) begin
      case (n)
        2'd1: grp.res[0].done_res = 1'b1;
        2'd2: grp.res[1].done_res = 1'b1;
        2'd3: grp.res[2].done_res = 1'b1;
        default: begin
          grp.count  = 2'd1;
          grp.res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b1,
                         bytes_written: 16'(wc_q)};
        end
      endcase
      mode_d  = jsud_pkg::MODE_NORMAL;
      hcnt_d  = 2'd0;
      acc_d   = 16'h0000;
      hstop_d = 1'b0;
      wc_d    = '0;
    end
  end

  assign grp_o = grp;

  // Per-string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jsud_pkg::MODE_NORMAL;
      hcnt_q  <= 2'd0;
      acc_q   <= 16'h0000;
      hstop_q <= 1'b0;
      wc_q    <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      hcnt_q  <= hcnt_d;
      acc_q   <= acc_d;
      hstop_q <= hstop_d;
      wc_q    <= wc_d;
    end
  end

endmodule

[src/jsud_res_buf.sv]
module jsud_res_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  jsud_pkg::res_grp_t grp_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jsud_pkg::out_t     out_res_o
);

  jsud_pkg::out_t [jsud_pkg::MaxRes-1:0] res_q;
  logic [1:0] rem_q;
  logic [1:0] idx_q;
  logic       pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign out_res_o   = res_q[idx_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Room for a new group once the last pending result leaves
  assign can_load_o  = (rem_q == 2'd0) || ((rem_q == 2'd1) && pop);

  // Pending result count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      rem_q <= grp_i.count;
      idx_q <= 2'd0;
    end else if (pop) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= grp_i.res;
    end
  end

endmodule

[src/jsud_checker.sv]
module jsud_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input jsud_pkg::in_t  in_req_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input jsud_pkg::out_t out_res_o
);

  // Empty result side never holds off the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no pending result");

  // Accepted string end shows a result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_req_i.in_last) |=> out_valid_o)
    else $error("no result after an accepted string end");

  // A bare marker is always the string end and carries a zero byte
  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_res_o.byte_valid) |->
      (out_res_o.done_res && (out_res_o.out_byte == 8'h00)))
    else $error("bare marker without done flag");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_res_o)))
    else $error("stalled result changed");

endmodule

bind json_string_unescape_decoder jsud_checker u_jsud_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
